@@ hdl/vprt_pkg.sv @@
// ----------------------------------------------------------------------------
// vprt_pkg: shared definitions for the virtual page request table
// Field widths, default parameter values, outcome codes and the command and
// status groups exchanged between the controller and the datapath.
// ----------------------------------------------------------------------------
package vprt_pkg;

  localparam int TABLE_DIM_DEF = 64;
  localparam int SLOT_COLS_DEF = 16;
  localparam int SLOT_ROWS_DEF = 16;

  localparam int COORD_W    = 24;
  localparam int FRAC_W     = 16;
  localparam int OUTCOME_W  = 2;
  localparam int PAGE_OUT_W = 6;
  localparam int SLOT_OUT_W = 8;
  localparam int SXY_OUT_W  = 4;
  localparam int COUNT_W    = 32;
  localparam int FREE_OUT_W = 9;

  typedef enum logic [OUTCOME_W-1:0] {
    OUTCOME_RESIDENT  = 2'd0,
    OUTCOME_ALLOCATED = 2'd1,
    OUTCOME_DROPPED   = 2'd2
  } outcome_t;

  typedef struct packed {
    logic clear;
    logic capture;
    logic map;
    logic lookup;
    logic resolve;
    logic finish;
  } vprt_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic hit;
    logic out_busy;
  } vprt_status_t;

endpackage

@@ hdl/vprt_ctrl.sv @@
// ----------------------------------------------------------------------------
// vprt_ctrl: request sequencer
// Steps each item through coordinate mapping, page table lookup, and then
// allocation, a drop when no slot is free, or a counter update, after running the table clear at reset.
// ----------------------------------------------------------------------------
module vprt_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  vprt_pkg::vprt_status_t status,
  output vprt_pkg::vprt_cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MAP,
    S_ADDR,
    S_TABLE,
    S_COUNT
  } state_t;

  state_t state;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd         = '0;
    cmd.clear   = (state == S_CLEAR);
    cmd.capture = in_valid && in_ready;
    cmd.map     = (state == S_MAP);
    cmd.lookup  = (state == S_ADDR);
    cmd.resolve = (state == S_TABLE) && !status.out_busy;
    cmd.finish  = (state == S_COUNT) && !status.out_busy;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      unique case (state)
        S_CLEAR: begin
          if (status.clear_last) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            state <= S_MAP;
          end
        end
        S_MAP: begin
          state <= S_ADDR;
        end
        S_ADDR: begin
          state <= S_TABLE;
        end
        S_TABLE: begin
          // A resident page still needs its use counter read and bumped.
          if (!status.out_busy) begin
            state <= status.hit ? S_COUNT : S_IDLE;
          end
        end
        S_COUNT: begin
          if (!status.out_busy) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_CLEAR;
        end
      endcase
    end
  end

endmodule

@@ hdl/vprt_dp.sv @@
// ----------------------------------------------------------------------------
// vprt_dp: request table datapath
// Coordinate to page mapping, page table and slot counter memories, free
// slot tracking and the output register.
// ----------------------------------------------------------------------------
module vprt_dp #(
  parameter int TABLE_DIM = vprt_pkg::TABLE_DIM_DEF,
  parameter int SLOT_COLS = vprt_pkg::SLOT_COLS_DEF,
  parameter int SLOT_ROWS = vprt_pkg::SLOT_ROWS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  vprt_pkg::vprt_cmd_t               cmd,
  output vprt_pkg::vprt_status_t            status,
  input  logic [vprt_pkg::COORD_W-1:0]      u_coord,
  input  logic [vprt_pkg::COORD_W-1:0]      v_coord,
  input  logic                              out_ready,
  output logic                              out_valid,
  output logic [vprt_pkg::OUTCOME_W-1:0]    outcome,
  output logic [vprt_pkg::PAGE_OUT_W-1:0]   page_x,
  output logic [vprt_pkg::PAGE_OUT_W-1:0]   page_y,
  output logic [vprt_pkg::SLOT_OUT_W-1:0]   slot_index,
  output logic [vprt_pkg::SXY_OUT_W-1:0]    slot_x,
  output logic [vprt_pkg::SXY_OUT_W-1:0]    slot_y,
  output logic [vprt_pkg::COUNT_W-1:0]      use_count,
  output logic [vprt_pkg::FREE_OUT_W-1:0]   free_left
);

  localparam int FRAC_W     = vprt_pkg::FRAC_W;
  localparam int COUNT_W    = vprt_pkg::COUNT_W;
  localparam int PAGE_W     = $clog2(TABLE_DIM);
  localparam int DIM_W      = $clog2(TABLE_DIM + 1);
  localparam int PROD_W     = FRAC_W + DIM_W;
  localparam int PAGE_COUNT = TABLE_DIM * TABLE_DIM;
  localparam int ADDR_W     = $clog2(PAGE_COUNT);
  localparam int SLOT_COUNT = SLOT_COLS * SLOT_ROWS;
  localparam int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int COL_W      = (SLOT_COLS > 1) ? $clog2(SLOT_COLS) : 1;
  localparam int ROW_W      = (SLOT_ROWS > 1) ? $clog2(SLOT_ROWS) : 1;
  localparam int FREE_W     = $clog2(SLOT_COUNT + 1);
  localparam int ENT_W      = 1 + SLOT_W + COL_W + ROW_W;

  // Capture and mapping registers.
  logic [FRAC_W-1:0] u_frac;
  logic [FRAC_W-1:0] v_frac;
  logic [PAGE_W-1:0] px;
  logic [PAGE_W-1:0] py;
  logic [PROD_W-1:0] u_prod;
  logic [PROD_W-1:0] v_prod;
  logic [ADDR_W-1:0] entry;

  // Page table: valid, slot and the slot's column and row, so that a hit
  // needs no division.
  logic [ENT_W-1:0]  tab_mem [PAGE_COUNT];
  logic [ENT_W-1:0]  tab_rd;
  logic [ENT_W-1:0]  tab_wdata;
  logic [ADDR_W-1:0] tab_waddr;
  logic              tab_we;
  logic [ADDR_W-1:0] clr_addr;

  logic              tab_valid;
  logic [SLOT_W-1:0] tab_slot;
  logic [COL_W-1:0]  tab_sx;
  logic [ROW_W-1:0]  tab_sy;

  logic [COUNT_W-1:0] cnt_mem [SLOT_COUNT];
  logic [COUNT_W-1:0] cnt_rd;
  logic [COUNT_W-1:0] cnt_inc;
  logic [COUNT_W-1:0] cnt_wdata;
  logic [SLOT_W-1:0]  cnt_waddr;
  logic               cnt_we;

  // Top of the free stack, kept with its column and row.
  logic [FREE_W-1:0] free;
  logic [SLOT_W-1:0] top_slot;
  logic [COL_W-1:0]  top_x;
  logic [ROW_W-1:0]  top_y;

  logic alloc;
  logic drop;
  logic load_out;

  assign u_prod = PROD_W'(u_frac) * PROD_W'(TABLE_DIM);
  assign v_prod = PROD_W'(v_frac) * PROD_W'(TABLE_DIM);
  assign entry  = ADDR_W'(ADDR_W'(px) * ADDR_W'(TABLE_DIM) + ADDR_W'(py));

  assign {tab_valid, tab_slot, tab_sx, tab_sy} = tab_rd;

  assign alloc    = cmd.resolve && !tab_valid && (free != '0);
  assign drop     = cmd.resolve && !tab_valid && (free == '0);
  assign load_out = alloc || drop || cmd.finish;
  assign cnt_inc  = cnt_rd + COUNT_W'(1);

  assign status.clear_last = (clr_addr == ADDR_W'(PAGE_COUNT - 1));
  assign status.hit        = tab_valid;
  assign status.out_busy   = out_valid && !out_ready;

  // The fraction alone sets the page: the integer part of the coordinate
  // only adds whole multiples of the table size, which the wrap removes.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      u_frac <= u_coord[FRAC_W-1:0];
      v_frac <= v_coord[FRAC_W-1:0];
    end
    if (cmd.map) begin
      px <= u_prod[FRAC_W +: PAGE_W];
      py <= v_prod[FRAC_W +: PAGE_W];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear) begin
      clr_addr <= clr_addr + ADDR_W'(1);
    end
  end

  always_comb begin
    tab_we    = cmd.clear || alloc;
    tab_waddr = cmd.clear ? clr_addr : entry;
    tab_wdata = cmd.clear ? '0 : {1'b1, top_slot, top_x, top_y};
  end

  always_ff @(posedge clk) begin
    if (tab_we) begin
      tab_mem[tab_waddr] <= tab_wdata;
    end
    if (cmd.lookup) begin
      tab_rd <= tab_mem[entry];
    end
  end

  // A slot is handed out only once, so its counter is zeroed when it is
  // allocated and needs no clearing at reset.
  always_comb begin
    cnt_we    = alloc || cmd.finish;
    cnt_waddr = cmd.finish ? tab_slot : top_slot;
    cnt_wdata = cmd.finish ? cnt_inc : '0;
  end

  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[cnt_waddr] <= cnt_wdata;
    end
    if (cmd.resolve && tab_valid) begin
      cnt_rd <= cnt_mem[tab_slot];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      free     <= FREE_W'(SLOT_COUNT);
      top_slot <= SLOT_W'(SLOT_COUNT - 1);
      top_x    <= COL_W'(SLOT_COLS - 1);
      top_y    <= ROW_W'(SLOT_ROWS - 1);
    end else if (alloc) begin
      free     <= free - FREE_W'(1);
      top_slot <= top_slot - SLOT_W'(1);
      if (top_x == '0) begin
        top_x <= COL_W'(SLOT_COLS - 1);
        top_y <= top_y - ROW_W'(1);
      end else begin
        top_x <= top_x - COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      page_x <= vprt_pkg::PAGE_OUT_W'(px);
      page_y <= vprt_pkg::PAGE_OUT_W'(py);
      if (cmd.finish) begin
        outcome    <= vprt_pkg::OUTCOME_RESIDENT;
        slot_index <= vprt_pkg::SLOT_OUT_W'(tab_slot);
        slot_x     <= vprt_pkg::SXY_OUT_W'(tab_sx);
        slot_y     <= vprt_pkg::SXY_OUT_W'(tab_sy);
        use_count  <= cnt_inc;
        free_left  <= vprt_pkg::FREE_OUT_W'(free);
      end else if (alloc) begin
        outcome    <= vprt_pkg::OUTCOME_ALLOCATED;
        slot_index <= vprt_pkg::SLOT_OUT_W'(top_slot);
        slot_x     <= vprt_pkg::SXY_OUT_W'(top_x);
        slot_y     <= vprt_pkg::SXY_OUT_W'(top_y);
        use_count  <= '0;
        free_left  <= vprt_pkg::FREE_OUT_W'(free - FREE_W'(1));
      end else begin
        outcome    <= vprt_pkg::OUTCOME_DROPPED;
        slot_index <= '0;
        slot_x     <= '0;
        slot_y     <= '0;
        use_count  <= '0;
        free_left  <= '0;
      end
    end
  end

  a_free_bound: assert property (@(posedge clk) disable iff (rst)
    free <= FREE_W'(SLOT_COUNT))
    else $error("free slot count above the slot total");

  a_top_matches_free: assert property (@(posedge clk) disable iff (rst)
    (free != '0) |-> (top_slot == SLOT_W'(free - FREE_W'(1))))
    else $error("free stack top out of step with the free count");

  a_top_position: assert property (@(posedge clk) disable iff (rst)
    (free != '0) |->
      (top_slot == SLOT_W'(SLOT_W'(top_y) * SLOT_W'(SLOT_COLS) + SLOT_W'(top_x))))
    else $error("free stack column and row do not match the slot");

  a_alloc_takes_one: assert property (@(posedge clk) disable iff (rst)
    alloc |=> (free == $past(free) - FREE_W'(1)) && out_valid)
    else $error("allocation did not consume exactly one slot");

  a_drop_only_when_full: assert property (@(posedge clk) disable iff (rst)
    drop |=> (free == '0) && (outcome == vprt_pkg::OUTCOME_DROPPED))
    else $error("item dropped while slots remained");

endmodule

@@ hdl/virtual_page_request_table.sv @@
// ----------------------------------------------------------------------------
// virtual_page_request_table: virtual texture page request table
// Maps u/v texture coordinates to a virtual page, allocates physical slots
// from a free stack on first touch and counts uses of resident pages.
// ----------------------------------------------------------------------------
// After reset the block clears its page table, one entry per cycle, for all
// TABLE_DIM*TABLE_DIM entries (4096 at the defaults); in_ready stays low
// during that pass. It then handles one item at a time. Each item passes
// through the registered coordinate multiply and the registered page table
// read; for a hit, the read-modify-write of the slot use counter memory
// follows. The result of an allocation, a drop or a hit is loaded into the
// output register only while that register is empty or its result is being
// taken. The next item is accepted as soon as the result has been loaded
// into the output register, even if that result has not yet been taken.
module virtual_page_request_table #(
  parameter int TABLE_DIM = vprt_pkg::TABLE_DIM_DEF,
  parameter int SLOT_COLS = vprt_pkg::SLOT_COLS_DEF,
  parameter int SLOT_ROWS = vprt_pkg::SLOT_ROWS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [vprt_pkg::COORD_W-1:0]      u_coord,
  input  logic [vprt_pkg::COORD_W-1:0]      v_coord,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [vprt_pkg::OUTCOME_W-1:0]    outcome,
  output logic [vprt_pkg::PAGE_OUT_W-1:0]   page_x,
  output logic [vprt_pkg::PAGE_OUT_W-1:0]   page_y,
  output logic [vprt_pkg::SLOT_OUT_W-1:0]   slot_index,
  output logic [vprt_pkg::SXY_OUT_W-1:0]    slot_x,
  output logic [vprt_pkg::SXY_OUT_W-1:0]    slot_y,
  output logic [vprt_pkg::COUNT_W-1:0]      use_count,
  output logic [vprt_pkg::FREE_OUT_W-1:0]   free_left
);

  vprt_pkg::vprt_cmd_t    cmd;
  vprt_pkg::vprt_status_t status;

  vprt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  vprt_dp #(
    .TABLE_DIM (TABLE_DIM),
    .SLOT_COLS (SLOT_COLS),
    .SLOT_ROWS (SLOT_ROWS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .u_coord    (u_coord),
    .v_coord    (v_coord),
    .out_ready  (out_ready),
    .out_valid  (out_valid),
    .outcome    (outcome),
    .page_x     (page_x),
    .page_y     (page_y),
    .slot_index (slot_index),
    .slot_x     (slot_x),
    .slot_y     (slot_y),
    .use_count  (use_count),
    .free_left  (free_left)
  );

endmodule

@@ tb/virtual_page_request_table_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// virtual_page_request_table_tb: self-checking bench for the page table
// Drives u/v coordinate requests through the valid/ready input, predicts
// the page, slot, use count and free count of every request, and checks
// each result in order. Covers wraparound, slot exhaustion, output stalls
// and random idling on both channels.
// ----------------------------------------------------------------------------
module virtual_page_request_table_tb;

  localparam int TB_TABLE_DIM  = vprt_pkg::TABLE_DIM_DEF;
  localparam int TB_SLOT_COLS  = vprt_pkg::SLOT_COLS_DEF;
  localparam int PAGE_COUNT    = TB_TABLE_DIM * TB_TABLE_DIM;
  localparam int SLOT_COUNT    = vprt_pkg::SLOT_COLS_DEF * vprt_pkg::SLOT_ROWS_DEF;
  localparam int STALL_CYCLES  = 300;
  localparam int DRAIN_LIMIT   = 5000;
  localparam int SETTLE_CYCLES = 20;

  localparam int COORD_W    = vprt_pkg::COORD_W;
  localparam int FRAC_W     = vprt_pkg::FRAC_W;
  localparam int OUTCOME_W  = vprt_pkg::OUTCOME_W;
  localparam int PAGE_OUT_W = vprt_pkg::PAGE_OUT_W;
  localparam int SLOT_OUT_W = vprt_pkg::SLOT_OUT_W;
  localparam int SXY_OUT_W  = vprt_pkg::SXY_OUT_W;
  localparam int COUNT_W    = vprt_pkg::COUNT_W;
  localparam int FREE_OUT_W = vprt_pkg::FREE_OUT_W;

  typedef struct {
    vprt_pkg::outcome_t      outcome;
    logic [PAGE_OUT_W-1:0]   page_x;
    logic [PAGE_OUT_W-1:0]   page_y;
    logic [SLOT_OUT_W-1:0]   slot_index;
    logic [SXY_OUT_W-1:0]    slot_x;
    logic [SXY_OUT_W-1:0]    slot_y;
    logic [COUNT_W-1:0]      use_count;
    logic [FREE_OUT_W-1:0]   free_left;
  } page_result_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [COORD_W-1:0]    u_coord = '0;
  logic [COORD_W-1:0]    v_coord = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [OUTCOME_W-1:0]  outcome;
  logic [PAGE_OUT_W-1:0] page_x;
  logic [PAGE_OUT_W-1:0] page_y;
  logic [SLOT_OUT_W-1:0] slot_index;
  logic [SXY_OUT_W-1:0]  slot_x;
  logic [SXY_OUT_W-1:0]  slot_y;
  logic [COUNT_W-1:0]    use_count;
  logic [FREE_OUT_W-1:0] free_left;

  // Shadow copy of the page table state.
  bit                    page_resident [PAGE_COUNT];
  logic [SLOT_OUT_W-1:0] page_slot_of  [PAGE_COUNT];
  logic [COUNT_W-1:0]    slot_uses     [SLOT_COUNT] = '{default: '0};
  int                    slots_left = SLOT_COUNT;
  int                    resident_entries [$];
  page_result_t          pending_page_results [$];

  int error_count = 0;
  int sent_count = 0;
  int checked_count = 0;
  int hit_count = 0;
  int alloc_count = 0;
  int drop_count = 0;

  bit source_idle = 1'b0;
  bit sink_idle = 1'b0;
  bit sink_hold = 1'b0;
  int sink_gap = 0;

  virtual_page_request_table DUT (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .u_coord    (u_coord),
    .v_coord    (v_coord),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .outcome    (outcome),
    .page_x     (page_x),
    .page_y     (page_y),
    .slot_index (slot_index),
    .slot_x     (slot_x),
    .slot_y     (slot_y),
    .use_count  (use_count),
    .free_left  (free_left)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    error_count++;
  endtask

  // Computes the result of one request and advances the shadow state.
  function automatic page_result_t predict_page_lookup(input logic [COORD_W-1:0] u,
                                                       input logic [COORD_W-1:0] v);
    page_result_t          r;
    longint unsigned       scaled_u;
    longint unsigned       scaled_v;
    int                    entry;
    logic [SLOT_OUT_W-1:0] slot;
    scaled_u = (longint'(u) * TB_TABLE_DIM) >> FRAC_W;
    scaled_v = (longint'(v) * TB_TABLE_DIM) >> FRAC_W;
    r.page_x = PAGE_OUT_W'(scaled_u % TB_TABLE_DIM);
    r.page_y = PAGE_OUT_W'(scaled_v % TB_TABLE_DIM);
    entry = int'(r.page_x) * TB_TABLE_DIM + int'(r.page_y);
    slot = '0;
    r.use_count = '0;
    if (page_resident[entry]) begin
      slot = page_slot_of[entry];
      slot_uses[slot] = slot_uses[slot] + COUNT_W'(1);
      r.use_count = slot_uses[slot];
      r.outcome = vprt_pkg::OUTCOME_RESIDENT;
      hit_count++;
    end else if (slots_left > 0) begin
      // Slots come off the free stack from the top down, never returned.
      slots_left--;
      slot = SLOT_OUT_W'(slots_left);
      page_slot_of[entry] = slot;
      page_resident[entry] = 1'b1;
      resident_entries.push_back(entry);
      r.use_count = slot_uses[slot];
      r.outcome = vprt_pkg::OUTCOME_ALLOCATED;
      alloc_count++;
    end else begin
      r.outcome = vprt_pkg::OUTCOME_DROPPED;
      drop_count++;
    end
    r.slot_index = slot;
    r.slot_x = SXY_OUT_W'(slot % TB_SLOT_COLS);
    r.slot_y = SXY_OUT_W'(slot / TB_SLOT_COLS);
    r.free_left = FREE_OUT_W'(slots_left);
    return r;
  endfunction

  task automatic set_idling(input bit on);
    source_idle = on;
    sink_idle <= on;
  endtask

  task automatic send_request(input logic [COORD_W-1:0] u, input logic [COORD_W-1:0] v);
    int gap;
    u_coord <= u;
    v_coord <= v;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    pending_page_results.push_back(predict_page_lookup(u, v));
    sent_count++;
    if (source_idle && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 12);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // A coordinate that lands on the given page, with random integer and
  // sub-page bits so that wraparound is exercised on every revisit.
  function automatic logic [COORD_W-1:0] coord_on_page(input int pg);
    return {8'($urandom), 6'(pg), 10'($urandom)};
  endfunction

  task automatic send_random_coords();
    send_request(24'($urandom), 24'($urandom));
  endtask

  task automatic revisit_request();
    int entry;
    if (resident_entries.size() == 0) begin
      send_random_coords();
    end else begin
      entry = resident_entries[$urandom_range(0, resident_entries.size() - 1)];
      send_request(coord_on_page(entry / TB_TABLE_DIM), coord_on_page(entry % TB_TABLE_DIM));
    end
  endtask

  task automatic send_untouched_page();
    int entry;
    do entry = $urandom_range(0, PAGE_COUNT - 1); while (page_resident[entry]);
    send_request(coord_on_page(entry / TB_TABLE_DIM), coord_on_page(entry % TB_TABLE_DIM));
  endtask

  task automatic test_corner_coords();
    set_idling(1'b0);
    send_request(24'h000000, 24'h000000);
    send_request(24'h000000, 24'h000000);
    send_request(24'hFFFFFF, 24'hFFFFFF);
    // Coordinates of 1.0 and 2.0 wrap back onto page (0, 0).
    send_request(24'h010000, 24'h020000);
    send_request(24'h00FFFF, 24'h000000);
    send_request(24'h000000, 24'h00FFFF);
    send_request(24'h000400, 24'h0003FF);
    send_request(24'hFF0000, 24'hFFFC00);
    send_request(24'h800000, 24'h7FFFFF);
    send_request(24'hAAAAAA, 24'h555555);
    send_request(24'h555555, 24'hAAAAAA);
    send_request(24'hFFFFFF, 24'hFFFFFF);
    send_request(24'h7FFFFF, 24'hFFFFFF);
  endtask

  task automatic test_random_requests(input int count);
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) set_idling($urandom_range(0, 2) != 0);
      if ($urandom_range(0, 9) < 7) revisit_request();
      else send_random_coords();
    end
  endtask

  // The sink holds off for a long stretch while requests keep coming, so the
  // output register and the pipeline fill and the input stalls.
  task automatic test_output_stall();
    set_idling(1'b0);
    fork
      begin
        sink_hold <= 1'b1;
        repeat (STALL_CYCLES) @(posedge clk);
        sink_hold <= 1'b0;
      end
      begin
        for (int i = 0; i < 20; i++) revisit_request();
      end
    join
  endtask

  task automatic test_table_exhaustion();
    set_idling(1'b1);
    while (slots_left > 0) begin
      send_untouched_page();
      if ($urandom_range(0, 3) == 0) revisit_request();
    end
    for (int i = 0; i < 40; i++) begin
      send_untouched_page();
      revisit_request();
    end
  endtask

  task automatic test_full_rate_tail(input int count);
    set_idling(1'b0);
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 3))
        0:       send_untouched_page();
        1:       send_random_coords();
        default: revisit_request();
      endcase
    end
    in_valid <= 1'b0;
  endtask

  task automatic check_field(input string name, input logic [COUNT_W-1:0] got,
                             input logic [COUNT_W-1:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("result %0d %s: got %0h, expected %0h",
                                checked_count, name, got, want));
    end
  endtask

  always @(posedge clk) begin : result_check
    page_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_page_results.size() == 0) begin
        report_mismatch("result arrived with no request outstanding");
      end else begin
        want = pending_page_results.pop_front();
        check_field("outcome", COUNT_W'(outcome), COUNT_W'(want.outcome));
        check_field("page_x", COUNT_W'(page_x), COUNT_W'(want.page_x));
        check_field("page_y", COUNT_W'(page_y), COUNT_W'(want.page_y));
        check_field("slot_index", COUNT_W'(slot_index), COUNT_W'(want.slot_index));
        check_field("slot_x", COUNT_W'(slot_x), COUNT_W'(want.slot_x));
        check_field("slot_y", COUNT_W'(slot_y), COUNT_W'(want.slot_y));
        check_field("use_count", use_count, want.use_count);
        check_field("free_left", COUNT_W'(free_left), COUNT_W'(want.free_left));
      end
      checked_count++;
    end
  end

  always @(posedge clk) begin : result_sink
    if (sink_hold) begin
      out_ready <= 1'b0;
    end else if (sink_gap > 0) begin
      out_ready <= 1'b0;
      sink_gap = sink_gap - 1;
    end else if (sink_idle && $urandom_range(0, 7) == 0) begin
      out_ready <= 1'b0;
      sink_gap = $urandom_range(0, 11);
    end else begin
      out_ready <= 1'b1;
    end
  end

  initial begin : run_tests
    int drain_cycles;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_corner_coords();
    test_random_requests(480);
    test_output_stall();
    test_table_exhaustion();
    test_full_rate_tail(330);
    drain_cycles = 0;
    while (pending_page_results.size() != 0 && drain_cycles < DRAIN_LIMIT) begin
      @(posedge clk);
      drain_cycles++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_page_results.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", pending_page_results.size()));
    end
    $display("Ran %0d requests, checked %0d results, %0d mismatches.",
             sent_count, checked_count, error_count);
    $display("Outcomes: %0d resident hits, %0d allocations, %0d dropped for lack of a slot.",
             hit_count, alloc_count, drop_count);
    if (error_count == 0) begin
      $display("virtual_page_request_table_tb passed");
    end else begin
      $display("virtual_page_request_table_tb failed");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("Timeout with %0d results outstanding.", pending_page_results.size());
    $display("virtual_page_request_table_tb failed");
    $finish;
  end

endmodule

@@ files.f @@
hdl/vprt_pkg.sv
hdl/vprt_ctrl.sv
hdl/vprt_dp.sv
hdl/virtual_page_request_table.sv
tb/virtual_page_request_table_tb.sv
